### rtl/core/akpb_pkg.sv
// ----------------------------------------------------------------------------
// akpb_pkg: shared types and constants for the additive key pixel blend
// Register map, luma modes, pixel and config structs, pipeline geometry.
// ----------------------------------------------------------------------------
package akpb_pkg;

  localparam int unsigned PixW       = 24;  // pixel field, signed Q11.12
  localparam int unsigned DiffW      = 25;  // screen minus reference
  localparam int unsigned AddrW      = 5;   // eight 32-bit registers
  localparam int unsigned DataW      = 32;

  // pipeline geometry: luma front end, then per-channel key back end
  localparam int unsigned LumaStages = 4;
  localparam int unsigned ChanStages = 6;
  localparam int unsigned NumStages  = LumaStages + ChanStages;

  // Q0.16 luma weights (each set sums to 1.0)
  localparam logic signed [16:0] Rec709R  = 17'sd13933;
  localparam logic signed [16:0] Rec709G  = 17'sd46871;
  localparam logic signed [16:0] Rec709B  = 17'sd4732;
  localparam logic signed [16:0] Ccir601R = 17'sd19595;
  localparam logic signed [16:0] Ccir601G = 17'sd38470;
  localparam logic signed [16:0] Ccir601B = 17'sd7471;

  // average: floor((sum + 1) / 3), biased by 3 * 2^24 to stay non-negative
  localparam logic [26:0] AvgBias    = 27'd50331649;
  localparam logic [25:0] AvgOffset  = 26'd16777216;
  localparam logic [31:0] RecipThird = 32'hAAAA_AAAB;  // ceil(2^33 / 3)

  localparam logic signed [26:0] KeyLimit = 27'sd4096000;  // 1000.0 in Q11.12
  localparam logic signed [PixW-1:0] PixMax = 24'sh7F_FFFF;
  localparam logic signed [PixW-1:0] PixMin = 24'sh80_0000;

  typedef enum logic [2:0] {
    RegRefRed         = 3'd0,
    RegRefGreen       = 3'd1,
    RegRefBlue        = 3'd2,
    RegLumaMode       = 3'd3,
    RegSaturation     = 3'd4,
    RegHighlightGain  = 3'd5,
    RegNegativeGain   = 3'd6,
    RegNegativeEnable = 3'd7
  } akpb_reg_e;

  typedef enum logic [1:0] {
    LumaRec709  = 2'd0,
    LumaCcir601 = 2'd1,
    LumaAverage = 2'd2,
    LumaMaximum = 2'd3
  } akpb_luma_e;

  typedef struct packed {
    logic signed [PixW-1:0] red;
    logic signed [PixW-1:0] green;
    logic signed [PixW-1:0] blue;
  } akpb_rgb_t;

  typedef struct packed {
    logic signed [DiffW:0] red;
    logic signed [DiffW:0] green;
    logic signed [DiffW:0] blue;
  } akpb_diff_t;

  typedef struct packed {
    logic signed [PixW-1:0] ref_red;
    logic signed [PixW-1:0] ref_green;
    logic signed [PixW-1:0] ref_blue;
    akpb_luma_e             luma_mode;
    logic [16:0]            sat_eff;    // saturation limited to 1.0
    logic [14:0]            highlight_gain;
    logic [14:0]            negative_gain;
    logic                   negative_enable;
  } akpb_cfg_t;

  typedef struct packed {
    logic [NumStages-1:0] en;  // load enable per register stage
  } akpb_pipe_t;

endpackage

### rtl/core/akpb_if.sv
// ----------------------------------------------------------------------------
// akpb_if: pixel stream interfaces
// Valid/ready channels for the input pixel pair and the keyed result.
// ----------------------------------------------------------------------------
interface akpb_in_if;
  import akpb_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [PixW-1:0] back_red;
  logic signed [PixW-1:0] back_green;
  logic signed [PixW-1:0] back_blue;
  logic signed [PixW-1:0] screen_red;
  logic signed [PixW-1:0] screen_green;
  logic signed [PixW-1:0] screen_blue;

  modport source (
    output valid, back_red, back_green, back_blue,
    output screen_red, screen_green, screen_blue,
    input  ready
  );
  modport sink (
    input  valid, back_red, back_green, back_blue,
    input  screen_red, screen_green, screen_blue,
    output ready
  );
endinterface

interface akpb_out_if;
  import akpb_pkg::*;

  logic                   valid;
  logic                   ready;
  logic signed [PixW-1:0] out_red;
  logic signed [PixW-1:0] out_green;
  logic signed [PixW-1:0] out_blue;

  modport source (output valid, out_red, out_green, out_blue, input ready);
  modport sink   (input  valid, out_red, out_green, out_blue, output ready);
endinterface

### rtl/core/additive_key_pixel_blend.sv
// ----------------------------------------------------------------------------
// additive_key_pixel_blend: additive keyer, one pixel per clock unless pix_o stalls
// Luma front end, three per-channel key lanes, APB register file.
// ----------------------------------------------------------------------------
// Usage:
//   pix_i carries a background pixel and a screen plate pixel (signed
//   Q11.12 per channel); pix_o returns the keyed pixel. Both are
//   valid/ready channels; a transfer happens when valid and ready are high
//   at a rising edge. The APB port sets the reference color, luma mode,
//   saturation and gains; write it only while no pixel is in flight.
//   From input transfer to pix_o.valid a pixel passes four luma stages
//   and six key stages, the last one being the output register.
//   Throughput: one pixel per clock while pix_o.ready stays high, set by
//   the ten-stage register pipeline; every stage holds its own valid bit.
//   Stall: when pix_o.ready is low the output holds; stages behind it keep
//   moving until they reach an occupied stage, so bubbles are squeezed out
//   and pix_i.ready only drops once every stage is full.
//   Reset (rst_ni low, asynchronous): all stages empty, registers cleared
//   to zero (Rec709 luma, zero saturation and gains, negative part off).
// ----------------------------------------------------------------------------
module additive_key_pixel_blend (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  akpb_in_if.sink                    pix_i,
  akpb_out_if.source                 pix_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [akpb_pkg::AddrW-1:0] paddr,
  input  logic [akpb_pkg::DataW-1:0] pwdata,
  output logic [akpb_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import akpb_pkg::*;

  akpb_cfg_t            cfg;
  akpb_pipe_t           pipe;
  logic [NumStages-1:0] valid_q;
  logic [NumStages:0]   move;     // stage k may load this cycle
  logic [NumStages-1:0] feed;     // valid presented to stage k

  akpb_rgb_t               back_in, screen_in, back_l;
  akpb_diff_t              diff_l;
  logic signed [DiffW-1:0] luma_l;

  akpb_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel_i    (psel),
    .penable_i (penable),
    .pwrite_i  (pwrite),
    .paddr_i   (paddr),
    .pwdata_i  (pwdata),
    .prdata_o  (prdata),
    .pready_o  (pready),
    .cfg_o     (cfg)
  );

  // ready ripples back: a stage can load when empty or when its content moves
  always_comb begin
    move[NumStages] = pix_o.ready;
    for (int k = NumStages - 1; k >= 0; k--) begin
      move[k] = !valid_q[k] || move[k+1];
    end
    feed    = {valid_q[NumStages-2:0], pix_i.valid};
    pipe.en = move[NumStages-1:0] & feed;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NumStages; k++) begin
        if (move[k]) valid_q[k] <= feed[k];
      end
    end
  end

  assign pix_i.ready = move[0];
  assign pix_o.valid = valid_q[NumStages-1];

  assign back_in.red     = pix_i.back_red;
  assign back_in.green   = pix_i.back_green;
  assign back_in.blue    = pix_i.back_blue;
  assign screen_in.red   = pix_i.screen_red;
  assign screen_in.green = pix_i.screen_green;
  assign screen_in.blue  = pix_i.screen_blue;

  akpb_luma u_luma (
    .clk_i    (clk_i),
    .cfg_i    (cfg),
    .pipe_i   (pipe),
    .back_i   (back_in),
    .screen_i (screen_in),
    .back_o   (back_l),
    .diff_o   (diff_l),
    .luma_o   (luma_l)
  );

  akpb_chan u_chan_red (
    .clk_i  (clk_i),
    .cfg_i  (cfg),
    .pipe_i (pipe),
    .back_i (back_l.red),
    .diff_i (diff_l.red),
    .luma_i (luma_l),
    .out_o  (pix_o.out_red)
  );

  akpb_chan u_chan_green (
    .clk_i  (clk_i),
    .cfg_i  (cfg),
    .pipe_i (pipe),
    .back_i (back_l.green),
    .diff_i (diff_l.green),
    .luma_i (luma_l),
    .out_o  (pix_o.out_green)
  );

  akpb_chan u_chan_blue (
    .clk_i  (clk_i),
    .cfg_i  (cfg),
    .pipe_i (pipe),
    .back_i (back_l.blue),
    .diff_i (diff_l.blue),
    .luma_i (luma_l),
    .out_o  (pix_o.out_blue)
  );

endmodule

### rtl/core/akpb_cfg.sv
// ----------------------------------------------------------------------------
// akpb_cfg: APB register file
// Eight keyer registers at word addresses, write on access phase, read mux.
// ----------------------------------------------------------------------------
module akpb_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel_i,
  input  logic                      penable_i,
  input  logic                      pwrite_i,
  input  logic [akpb_pkg::AddrW-1:0] paddr_i,
  input  logic [akpb_pkg::DataW-1:0] pwdata_i,
  output logic [akpb_pkg::DataW-1:0] prdata_o,
  output logic                      pready_o,
  output akpb_pkg::akpb_cfg_t       cfg_o
);
  import akpb_pkg::*;

  logic signed [PixW-1:0] ref_red_q, ref_green_q, ref_blue_q;
  akpb_luma_e             luma_mode_q;
  logic [16:0]            saturation_q;
  logic [14:0]            highlight_gain_q, negative_gain_q;
  logic                   negative_enable_q;
  logic                   wr_en;
  akpb_reg_e              reg_sel;

  assign wr_en    = psel_i && penable_i && pwrite_i;
  assign reg_sel  = akpb_reg_e'(paddr_i[4:2]);
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_red_q         <= '0;
      ref_green_q       <= '0;
      ref_blue_q        <= '0;
      luma_mode_q       <= LumaRec709;
      saturation_q      <= '0;
      highlight_gain_q  <= '0;
      negative_gain_q   <= '0;
      negative_enable_q <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_sel)
        RegRefRed:         ref_red_q         <= pwdata_i[PixW-1:0];
        RegRefGreen:       ref_green_q       <= pwdata_i[PixW-1:0];
        RegRefBlue:        ref_blue_q        <= pwdata_i[PixW-1:0];
        RegLumaMode:       luma_mode_q       <= akpb_luma_e'(pwdata_i[1:0]);
        RegSaturation:     saturation_q      <= pwdata_i[16:0];
        RegHighlightGain:  highlight_gain_q  <= pwdata_i[14:0];
        RegNegativeGain:   negative_gain_q   <= pwdata_i[14:0];
        RegNegativeEnable: negative_enable_q <= pwdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegRefRed:         prdata_o = DataW'(ref_red_q);
      RegRefGreen:       prdata_o = DataW'(ref_green_q);
      RegRefBlue:        prdata_o = DataW'(ref_blue_q);
      RegLumaMode:       prdata_o = DataW'(luma_mode_q);
      RegSaturation:     prdata_o = DataW'(saturation_q);
      RegHighlightGain:  prdata_o = DataW'(highlight_gain_q);
      RegNegativeGain:   prdata_o = DataW'(negative_gain_q);
      RegNegativeEnable: prdata_o = DataW'(negative_enable_q);
      default:           prdata_o = '0;
    endcase
  end

  always_comb begin
    cfg_o.ref_red         = ref_red_q;
    cfg_o.ref_green       = ref_green_q;
    cfg_o.ref_blue        = ref_blue_q;
    cfg_o.luma_mode       = luma_mode_q;
    // anything above 1.0 acts as 1.0
    cfg_o.sat_eff         = saturation_q[16] ? 17'h10000 : saturation_q;
    cfg_o.highlight_gain  = highlight_gain_q;
    cfg_o.negative_gain   = negative_gain_q;
    cfg_o.negative_enable = negative_enable_q;
  end

endmodule

### rtl/core/akpb_luma.sv
// ----------------------------------------------------------------------------
// akpb_luma: color difference and luma front end
// Four stages: difference, weight products, luma terms, luma select.
// ----------------------------------------------------------------------------
module akpb_luma (
  input  logic                 clk_i,
  input  akpb_pkg::akpb_cfg_t  cfg_i,
  input  akpb_pkg::akpb_pipe_t pipe_i,
  input  akpb_pkg::akpb_rgb_t  back_i,
  input  akpb_pkg::akpb_rgb_t  screen_i,
  output akpb_pkg::akpb_rgb_t  back_o,
  output akpb_pkg::akpb_diff_t diff_o,
  output logic signed [akpb_pkg::DiffW-1:0] luma_o
);
  import akpb_pkg::*;

  // stage 1
  logic signed [DiffW-1:0] d1_q [3];
  akpb_rgb_t               back1_q;
  // stage 2
  logic signed [41:0]      wp2_q [3];
  logic [26:0]             avgx2_q;
  logic signed [DiffW-1:0] max2_q;
  logic signed [DiffW-1:0] d2_q [3];
  akpb_rgb_t               back2_q;
  // stage 3
  logic signed [DiffW-1:0] wl3_q;
  logic [25:0]             quot3_q;
  logic signed [DiffW-1:0] max3_q;
  logic signed [DiffW-1:0] d3_q [3];
  akpb_rgb_t               back3_q;
  // stage 4
  logic signed [DiffW-1:0] luma4_q;
  logic signed [DiffW:0]   diff4_q [3];
  akpb_rgb_t               back4_q;

  logic signed [DiffW-1:0] d1_d [3];
  logic signed [PixW-1:0]  scr [3];
  logic signed [PixW-1:0]  refc [3];
  logic signed [16:0]      coef [3];
  logic signed [41:0]      wsum;
  logic [58:0]             avg_prod;
  logic signed [DiffW-1:0] max_d;
  logic [25:0]             avg_w;
  logic signed [DiffW-1:0] luma_d;

  always_comb begin
    scr[0]  = screen_i.red;
    scr[1]  = screen_i.green;
    scr[2]  = screen_i.blue;
    refc[0] = cfg_i.ref_red;
    refc[1] = cfg_i.ref_green;
    refc[2] = cfg_i.ref_blue;
    for (int i = 0; i < 3; i++) begin
      d1_d[i] = DiffW'(scr[i]) - DiffW'(refc[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[0]) begin
      d1_q    <= d1_d;
      back1_q <= back_i;
    end
  end

  // stage 2: weighted products, biased sum for the average, running maximum
  always_comb begin
    if (cfg_i.luma_mode == LumaCcir601) begin
      coef[0] = Ccir601R;
      coef[1] = Ccir601G;
      coef[2] = Ccir601B;
    end else begin
      coef[0] = Rec709R;
      coef[1] = Rec709G;
      coef[2] = Rec709B;
    end
    max_d = d1_q[0];
    if (d1_q[1] > max_d) max_d = d1_q[1];
    if (d1_q[2] > max_d) max_d = d1_q[2];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[1]) begin
      for (int i = 0; i < 3; i++) begin
        wp2_q[i] <= 42'(d1_q[i]) * 42'(coef[i]);
      end
      avgx2_q <= 27'(d1_q[0]) + 27'(d1_q[1]) + 27'(d1_q[2]) + AvgBias;
      max2_q  <= max_d;
      d2_q    <= d1_q;
      back2_q <= back1_q;
    end
  end

  // stage 3: round the weighted sum, divide the average by three
  assign wsum     = wp2_q[0] + wp2_q[1] + wp2_q[2] + 42'sd32768;
  assign avg_prod = 59'(avgx2_q) * 59'(RecipThird);

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[2]) begin
      wl3_q   <= wsum[40:16];
      quot3_q <= avg_prod[58:33];
      max3_q  <= max2_q;
      d3_q    <= d2_q;
      back3_q <= back2_q;
    end
  end

  // stage 4: pick the luma, form per-channel distance from it
  assign avg_w = quot3_q - AvgOffset;

  always_comb begin
    unique case (cfg_i.luma_mode)
      LumaRec709, LumaCcir601: luma_d = wl3_q;
      LumaAverage:             luma_d = avg_w[DiffW-1:0];
      LumaMaximum:             luma_d = max3_q;
      default:                 luma_d = wl3_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[3]) begin
      luma4_q <= luma_d;
      for (int i = 0; i < 3; i++) begin
        diff4_q[i] <= (DiffW+1)'(d3_q[i]) - (DiffW+1)'(luma_d);
      end
      back4_q <= back3_q;
    end
  end

  assign back_o       = back4_q;
  assign luma_o       = luma4_q;
  assign diff_o.red   = diff4_q[0];
  assign diff_o.green = diff4_q[1];
  assign diff_o.blue  = diff4_q[2];

endmodule

### rtl/core/akpb_chan.sv
// ----------------------------------------------------------------------------
// akpb_chan: per-channel key and blend
// Six stages: saturation product, clamp, gain, back product, round, saturate.
// ----------------------------------------------------------------------------
module akpb_chan (
  input  logic                             clk_i,
  input  akpb_pkg::akpb_cfg_t              cfg_i,
  input  akpb_pkg::akpb_pipe_t             pipe_i,
  input  logic signed [akpb_pkg::PixW-1:0] back_i,
  input  logic signed [akpb_pkg::DiffW:0]  diff_i,
  input  logic signed [akpb_pkg::DiffW-1:0] luma_i,
  output logic signed [akpb_pkg::PixW-1:0] out_o
);
  import akpb_pkg::*;

  localparam int unsigned E0 = LumaStages;

  logic signed [42:0]      prod5_q;
  logic signed [DiffW-1:0] luma5_q;
  logic signed [PixW-1:0]  back5_q;
  logic [21:0]             pos6_q;
  logic signed [22:0]      neg6_q;
  logic signed [PixW-1:0]  back6_q;
  logic signed [37:0]      key7_q;
  logic signed [PixW-1:0]  back7_q;
  logic signed [44:0]      plo8_q;
  logic signed [41:0]      phi8_q;
  logic signed [PixW-1:0]  back8_q;
  logic signed [37:0]      term9_q;
  logic signed [PixW-1:0]  back9_q;
  logic signed [PixW-1:0]  out10_q;

  logic signed [42:0]      prod_rnd;
  logic signed [26:0]      v;
  logic [21:0]             pos_d;
  logic signed [22:0]      neg_d;
  logic [36:0]             hterm;
  logic signed [37:0]      nterm;
  logic signed [61:0]      total;
  logic signed [38:0]      sum;
  logic signed [PixW-1:0]  out_d;

  // stage 5: (d - luma) * saturation
  always_ff @(posedge clk_i) begin
    if (pipe_i.en[E0]) begin
      prod5_q <= 43'(diff_i) * 43'(signed'({1'b0, cfg_i.sat_eff}));
      luma5_q <= luma_i;
      back5_q <= back_i;
    end
  end

  // stage 6: blended value, split into clamped positive and negative parts
  assign prod_rnd = prod5_q + 43'sd32768;
  assign v        = 27'(luma5_q) + prod_rnd[42:16];

  always_comb begin
    if (v <= 0)             pos_d = '0;
    else if (v > KeyLimit)  pos_d = KeyLimit[21:0];
    else                    pos_d = v[21:0];
    if (v >= 0)             neg_d = '0;
    else if (v < -KeyLimit) neg_d = 23'(-KeyLimit);
    else                    neg_d = v[22:0];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[E0+1]) begin
      pos6_q  <= pos_d;
      neg6_q  <= neg_d;
      back6_q <= back5_q;
    end
  end

  // stage 7: gains
  assign hterm = 37'(cfg_i.highlight_gain) * 37'(pos6_q);
  assign nterm = 38'(signed'({1'b0, cfg_i.negative_gain})) * 38'(neg6_q);

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[E0+2]) begin
      key7_q  <= signed'({1'b0, hterm}) + (cfg_i.negative_enable ? nterm : '0);
      back7_q <= back6_q;
    end
  end

  // stage 8: key * back as two partial products (low 20 bits, signed high part)
  always_ff @(posedge clk_i) begin
    if (pipe_i.en[E0+3]) begin
      plo8_q  <= 45'(signed'({1'b0, key7_q[19:0]})) * 45'(back7_q);
      phi8_q  <= 42'(signed'(key7_q[37:20])) * 42'(back7_q);
      back8_q <= back7_q;
    end
  end

  // stage 9: recombine and round by 2^24
  assign total = (62'(phi8_q) <<< 20) + 62'(plo8_q) + 62'sd8388608;

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[E0+4]) begin
      term9_q <= total[61:24];
      back9_q <= back8_q;
    end
  end

  // stage 10: add to background, saturate
  assign sum = 39'(back9_q) + 39'(term9_q);

  always_comb begin
    if (sum > 39'(PixMax))      out_d = PixMax;
    else if (sum < 39'(PixMin)) out_d = PixMin;
    else                        out_d = sum[PixW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (pipe_i.en[E0+5]) begin
      out10_q <= out_d;
    end
  end

  assign out_o = out10_q;

endmodule

### test/akpb_blend_checker.sv
// ----------------------------------------------------------------------------
// akpb_blend_checker: scoreboard for the additive key pixel blend
// Follows APB writes to keep its own copy of the registers, works out the
// keyed pixel for every input transfer and checks output transfers in order.
// ----------------------------------------------------------------------------
module akpb_blend_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  akpb_in_if                         pix_in_i,
  akpb_out_if                        pix_out_i,
  input  logic                       psel_i,
  input  logic                       penable_i,
  input  logic                       pwrite_i,
  input  logic [akpb_pkg::AddrW-1:0] paddr_i,
  input  logic [akpb_pkg::DataW-1:0] pwdata_i,
  input  logic                       pready_i,
  output int                         mismatch_cnt_o,
  output int                         pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import akpb_pkg::*;

  // register copy, all zero after reset
  bit signed [PixW-1:0] ref_r = '0;
  bit signed [PixW-1:0] ref_g = '0;
  bit signed [PixW-1:0] ref_b = '0;
  akpb_luma_e           luma_sel = LumaRec709;
  bit [16:0]            sat_q = '0;
  bit [14:0]            hl_gain_q = '0;
  bit [14:0]            neg_gain_q = '0;
  bit                   neg_en_q = 1'b0;

  akpb_rgb_t keyed_q[$];

  function automatic longint rnd_shift(longint x, int unsigned n);
    return (x + (longint'(1) <<< (n - 1))) >>> n;
  endfunction

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic logic signed [PixW-1:0] key_lane(longint back, longint diff,
                                                      longint luma, longint sat);
    longint blend;
    longint key;
    longint sum;
    blend = luma + rnd_shift((diff - luma) * sat, 16);
    key = longint'(hl_gain_q) * clip(blend, 0, longint'(KeyLimit));
    if (neg_en_q) begin
      key += longint'(neg_gain_q) * clip(blend, -longint'(KeyLimit), 0);
    end
    sum = clip(back + rnd_shift(key * back, 24), longint'(PixMin), longint'(PixMax));
    return sum[PixW-1:0];
  endfunction

  function automatic akpb_rgb_t blend_pixel(akpb_rgb_t back, akpb_rgb_t screen);
    longint dr, dg, db, luma, num, sat;
    akpb_rgb_t res;
    dr = longint'(screen.red) - longint'(ref_r);
    dg = longint'(screen.green) - longint'(ref_g);
    db = longint'(screen.blue) - longint'(ref_b);
    sat = (sat_q > 17'd65536) ? 65536 : longint'(sat_q);
    case (luma_sel)
      LumaRec709: begin
        luma = rnd_shift(longint'(Rec709R) * dr + longint'(Rec709G) * dg
                         + longint'(Rec709B) * db, 16);
      end
      LumaCcir601: begin
        luma = rnd_shift(longint'(Ccir601R) * dr + longint'(Ccir601G) * dg
                         + longint'(Ccir601B) * db, 16);
      end
      LumaAverage: begin
        // sum / 3 to nearest, ties up: floor((2 * sum + 3) / 6)
        num = 2 * (dr + dg + db) + 3;
        luma = num / 6;
        if ((num % 6) != 0 && num < 0) begin
          luma--;
        end
      end
      default: begin
        luma = dr;
        if (dg > luma) luma = dg;
        if (db > luma) luma = db;
      end
    endcase
    res.red   = key_lane(longint'(back.red), dr, luma, sat);
    res.green = key_lane(longint'(back.green), dg, luma, sat);
    res.blue  = key_lane(longint'(back.blue), db, luma, sat);
    return res;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatch_cnt_o++;
  endtask

  task automatic check_field(string name, logic signed [PixW-1:0] got,
                             logic signed [PixW-1:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    akpb_rgb_t back, screen, got, want;
    if (!rst_ni) begin
      ref_r      = '0;
      ref_g      = '0;
      ref_b      = '0;
      luma_sel   = LumaRec709;
      sat_q      = '0;
      hl_gain_q  = '0;
      neg_gain_q = '0;
      neg_en_q   = 1'b0;
      keyed_q.delete();
      pending_o  = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (akpb_reg_e'(paddr_i[4:2]))
          RegRefRed:         ref_r = pwdata_i[PixW-1:0];
          RegRefGreen:       ref_g = pwdata_i[PixW-1:0];
          RegRefBlue:        ref_b = pwdata_i[PixW-1:0];
          RegLumaMode:       luma_sel = akpb_luma_e'(pwdata_i[1:0]);
          RegSaturation:     sat_q = pwdata_i[16:0];
          RegHighlightGain:  hl_gain_q = pwdata_i[14:0];
          RegNegativeGain:   neg_gain_q = pwdata_i[14:0];
          RegNegativeEnable: neg_en_q = pwdata_i[0];
          default: ;
        endcase
      end
      if (pix_in_i.valid && pix_in_i.ready) begin
        back.red     = pix_in_i.back_red;
        back.green   = pix_in_i.back_green;
        back.blue    = pix_in_i.back_blue;
        screen.red   = pix_in_i.screen_red;
        screen.green = pix_in_i.screen_green;
        screen.blue  = pix_in_i.screen_blue;
        keyed_q.push_back(blend_pixel(back, screen));
      end
      if (pix_out_i.valid && pix_out_i.ready) begin
        got.red   = pix_out_i.out_red;
        got.green = pix_out_i.out_green;
        got.blue  = pix_out_i.out_blue;
        if (keyed_q.size() == 0) begin
          flag_mismatch("output transfer with no pixel outstanding");
        end else begin
          want = keyed_q.pop_front();
          check_field("out_red", got.red, want.red);
          check_field("out_green", got.green, want.green);
          check_field("out_blue", got.blue, want.blue);
        end
      end
      pending_o = keyed_q.size();
    end
  end

endmodule

### test/tb_additive_key_pixel_blend.sv
// ----------------------------------------------------------------------------
// tb_additive_key_pixel_blend: testbench top for the additive key pixel blend
// Drives the APB register port and the pixel stream, with directed corner
// pixels per luma mode, then random phases under varying idle and stall.
// ----------------------------------------------------------------------------
module tb_additive_key_pixel_blend;
  timeunit 1ns;
  timeprecision 1ps;
  import akpb_pkg::*;

  // Clock and reset
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  always #2 clk_i = ~clk_i;

  // APB configuration port
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  // Pixel channels
  akpb_in_if  pix_in ();
  akpb_out_if pix_out ();

  int mismatches;
  int pending;

  // Idle knobs, percent of cycles: sender gap and receiver stall
  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;

  additive_key_pixel_blend u_top (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_in),
    .pix_o   (pix_out),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  akpb_blend_checker u_chk (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .pix_in_i       (pix_in),
    .pix_out_i      (pix_out),
    .psel_i         (psel),
    .penable_i      (penable),
    .pwrite_i       (pwrite),
    .paddr_i        (paddr),
    .pwdata_i       (pwdata),
    .pready_i       (pready),
    .mismatch_cnt_o (mismatches),
    .pending_o      (pending)
  );

  // Receiver: one ready decision per cycle, so one NBA per time step
  always @(posedge clk_i) begin
    pix_out.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // APB write: setup cycle, access cycle, register lands on the pready edge
  task automatic apb_write(input akpb_reg_e idx, input logic [DataW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_blend_config(input logic signed [PixW-1:0] rr,
                                  input logic signed [PixW-1:0] rg,
                                  input logic signed [PixW-1:0] rb,
                                  input akpb_luma_e mode, input logic [16:0] sat,
                                  input logic [14:0] hl, input logic [14:0] ng,
                                  input logic ne);
    apb_write(RegRefRed, {8'h00, rr});
    apb_write(RegRefGreen, {8'h00, rg});
    apb_write(RegRefBlue, {8'h00, rb});
    apb_write(RegLumaMode, {30'd0, mode});
    apb_write(RegSaturation, {15'd0, sat});
    apb_write(RegHighlightGain, {17'd0, hl});
    apb_write(RegNegativeGain, {17'd0, ng});
    apb_write(RegNegativeEnable, {31'd0, ne});
  endtask

  // One pixel pair transfer. Valid drops only when a gap is taken, so a
  // back-to-back transfer never sees valid lowered and raised in one step.
  task automatic send_pixel(input akpb_rgb_t back, input akpb_rgb_t screen);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < src_idle_pct) gap++;
    if (gap > 0) begin
      pix_in.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    pix_in.valid        <= 1'b1;
    pix_in.back_red     <= back.red;
    pix_in.back_green   <= back.green;
    pix_in.back_blue    <= back.blue;
    pix_in.screen_red   <= screen.red;
    pix_in.screen_green <= screen.green;
    pix_in.screen_blue  <= screen.blue;
    do @(posedge clk_i); while (!pix_in.ready);
  endtask

  // Stop sending, wait for every outstanding pixel, then stay idle so that
  // registers can be touched safely.
  task automatic drain_pipe();
    int guard;
    pix_in.valid <= 1'b0;
    @(posedge clk_i);
    guard = 0;
    while (pending != 0 && guard < 20000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (2 * NumStages) @(posedge clk_i);
  endtask

  // Mix of full-range, near-unity and mid-range values so the clamps,
  // saturation and gains all get meaningful traffic.
  function automatic logic signed [PixW-1:0] rand_pix();
    int v;
    case ($urandom_range(3))
      0:       v = int'($urandom);
      1:       v = int'($urandom_range(32768)) - 16384;
      2:       v = int'($urandom_range(2097152)) - 1048576;
      default: v = int'($urandom_range(8192));
    endcase
    return v[PixW-1:0];
  endfunction

  function automatic akpb_rgb_t rand_rgb();
    akpb_rgb_t p;
    p.red   = rand_pix();
    p.green = rand_pix();
    p.blue  = rand_pix();
    return p;
  endfunction

  function automatic logic signed [PixW-1:0] rand_ref();
    case ($urandom_range(4))
      0:       return PixMin;
      1:       return PixMax;
      2:       return '0;
      default: return rand_pix();
    endcase
  endfunction

  // Gains span zero, nominal top (5.0), full 15-bit value and random
  function automatic logic [14:0] rand_gain();
    case ($urandom_range(4))
      0:       return 15'd0;
      1:       return 15'd20480;
      2:       return 15'h7FFF;
      3:       return 15'($urandom_range(20480));
      default: return 15'($urandom);
    endcase
  endfunction

  function automatic logic [16:0] rand_sat();
    case ($urandom_range(4))
      0:       return 17'd0;
      1:       return 17'd65536;
      2:       return 17'h1FFFF;
      3:       return 17'($urandom_range(65536));
      default: return 17'($urandom);
    endcase
  endfunction

  // Safety net: far beyond the slowest legal run
  initial begin : watchdog
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    akpb_rgb_t  back, screen;
    akpb_luma_e mode;

    // Everything known from time zero
    psel                = 1'b0;
    penable             = 1'b0;
    pwrite              = 1'b0;
    paddr               = '0;
    pwdata              = '0;
    pix_in.valid        = 1'b0;
    pix_in.back_red     = '0;
    pix_in.back_green   = '0;
    pix_in.back_blue    = '0;
    pix_in.screen_red   = '0;
    pix_in.screen_green = '0;
    pix_in.screen_blue  = '0;
    pix_out.ready       = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers: zero gains, so the background must pass unchanged
    send_pixel('{red: 24'sd4096, green: -24'sd4096, blue: PixMax},
               '{red: PixMin, green: 24'sd0, blue: PixMax});
    drain_pipe();

    // Directed corners, one group per luma mode. Groups also cover
    // saturation above one, gains at full 15-bit value and the negative
    // part switched off.
    for (int m = 0; m < 4; m++) begin
      mode = akpb_luma_e'(m);
      case (mode)
        LumaRec709:  set_blend_config('0, '0, '0, mode, 17'h1FFFF, 15'h7FFF,
                                      15'h7FFF, 1'b1);
        LumaCcir601: set_blend_config(PixMax, PixMin, '0, mode, 17'd65536,
                                      15'd20480, 15'd20480, 1'b0);
        LumaAverage: set_blend_config(PixMin, PixMax, 24'sd4096, mode, 17'd32768,
                                      15'd4096, 15'd8192, 1'b1);
        default:     set_blend_config('0, '0, '0, mode, 17'd0, 15'd0, 15'd20480,
                                      1'b1);
      endcase
      send_pixel('{red: PixMax, green: PixMax, blue: PixMax},
                 '{red: PixMax, green: PixMax, blue: PixMax});
      send_pixel('{red: PixMin, green: PixMin, blue: PixMin},
                 '{red: PixMin, green: PixMin, blue: PixMin});
      send_pixel('{red: PixMax, green: PixMax, blue: PixMax},
                 '{red: PixMin, green: PixMin, blue: PixMin});
      // just past the +/-1000 key clamp on red and blue
      send_pixel('{red: 24'sd4096, green: 24'sd8192, blue: -24'sd4096},
                 '{red: 24'sd4500000, green: 24'sd4096, blue: -24'sd4500000});
      send_pixel('{red: PixMin, green: 24'sd0, blue: PixMax},
                 '{red: PixMax, green: PixMin, blue: 24'sd0});
      drain_pipe();
    end

    // Random phases: each one a fresh register setting and idle pattern
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 66; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 66; end
        default: begin src_idle_pct = 37; sink_stall_pct = 37; end
      endcase
      mode = (ph < 4) ? akpb_luma_e'(ph) : akpb_luma_e'($urandom_range(3));
      set_blend_config(rand_ref(), rand_ref(), rand_ref(), mode, rand_sat(),
                       rand_gain(), rand_gain(), 1'($urandom));
      for (int i = 0; i < 100; i++) begin
        back   = rand_rgb();
        screen = rand_rgb();
        send_pixel(back, screen);
        // once: hold off until the pipe has fully emptied, then resume
        if (ph == 5 && i == 50) begin
          drain_pipe();
        end
      end
      drain_pipe();
    end

    if (mismatches == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
